>>> rtl/block_buffer_cache_manager_unit_defines.svh
// Assertion macros shared by the checker of the buffer cache manager.
// Needs a clk and an arst_n in the scope of use.
`ifndef BLOCK_BUFFER_CACHE_MANAGER_UNIT_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_UNIT_DEFINES_SVH
// implication checked in the same cycle
`define BBCM_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication checked in the next cycle
`define BBCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/bbcm_pkg.sv
// Types and constants of the block buffer cache manager.
// No dependencies.
package bbcm_pkg;
	typedef enum logic [2:0] {
		C_GET = 3'd0, C_READ = 3'd1, C_RELEASE = 3'd2, C_IODONE = 3'd3,
		C_WRITE = 3'd4, C_DELWRI = 3'd5, C_FLUSH = 3'd6
	} cmd_code_t;

	typedef enum logic [2:0] {
		K_GRANT = 3'd0, K_READ = 3'd1, K_WRITE = 3'd2, K_BUSY = 3'd3,
		K_NOFREE = 3'd4, K_NODEV = 3'd5, K_ACK = 3'd6
	} kind_t;

	// byte address of the device count register
	localparam logic [2:0] REG_DEV_COUNT = 3'd0;

	localparam int FLAG_W = 7;
	localparam logic [FLAG_W-1:0] F_BUSY   = 7'h01;
	localparam logic [FLAG_W-1:0] F_WANTED = 7'h02;
	localparam logic [FLAG_W-1:0] F_DONE   = 7'h04;
	localparam logic [FLAG_W-1:0] F_DELWRI = 7'h08;
	localparam logic [FLAG_W-1:0] F_ASYNC  = 7'h10;
	localparam logic [FLAG_W-1:0] F_READ   = 7'h20;
	localparam logic [FLAG_W-1:0] F_ERROR  = 7'h40;

	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] MAX_VICTIMS = 5'd16;
	localparam logic [CNT_W-1:0] MAX_FLUSH   = 5'd18;

	typedef enum logic [2:0] {
		CUR_KEEP = 3'd0, CUR_B = 3'd1, CUR_SCAN = 3'd2, CUR_HEAD = 3'd3, CUR_NEXT = 3'd4
	} cur_sel_t;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001, S_DISP  = 16'h0002, S_SRCH0  = 16'h0004, S_SEARCH = 16'h0008,
		S_MATCH  = 16'h0010, S_ALLOC = 16'h0020, S_ALLOC2 = 16'h0040, S_CLAIM  = 16'h0080,
		S_GRANT  = 16'h0100, S_GRANT2 = 16'h0200, S_WB    = 16'h0400, S_REL1   = 16'h0800,
		S_REL2   = 16'h1000, S_FL0   = 16'h2000, S_FL1    = 16'h4000, S_FIN    = 16'h8000
	} state_t;

	typedef struct packed {
		logic               load;
		cur_sel_t           cur_sel;
		logic               scan_clr;
		logic               scan_inc;
		logic [FLAG_W-1:0]  fset;
		logic [FLAG_W-1:0]  fclr;
		logic               unlink;
		logic               append;
		logic               tag_wr;
		logic               cnt_inc;
		logic               emit;
		kind_t              kind;
		logic               emit_tags;
		logic               emit_buf;
		logic               emit_hit;
		logic               finish;
	} dp_cmd_t;

	typedef struct packed {
		cmd_code_t          cmd;
		logic               nodev;
		logic               dev_neg;
		logic               valid_b;
		logic               scan_match;
		logic               scan_last;
		logic [FLAG_W-1:0]  cur_flags;
		logic               cur_end;
		logic               max_victims;
		logic               max_flush;
		logic               flush_match;
		logic               emit_ok;
		logic               out_free;
	} dp_sts_t;
endpackage

>>> rtl/bbcm_dp.sv
// Datapath: buffer tags, flags, LRU free list and the result staging registers.
// Depends on bbcm_pkg; driven by bbcm_ctrl.
module bbcm_dp #(
	parameter int BUFFER_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbcm_pkg::dp_cmd_t    dcmd,
	output bbcm_pkg::dp_sts_t    sts,
	input  logic [7:0]           dev_count,
	input  logic [2:0]           in_cmd,
	input  logic [15:0]          in_device,
	input  logic [23:0]          in_block,
	input  logic [3:0]           in_buffer,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           out_kind,
	output logic [3:0]           out_buffer,
	output logic [15:0]          out_device,
	output logic [23:0]          out_block,
	output logic                 out_hit,
	output logic                 out_last
);
	localparam int IW = $clog2(BUFFER_COUNT);
	localparam int PW = $clog2(BUFFER_COUNT + 1);
	localparam logic [PW-1:0] SENT = PW'(BUFFER_COUNT);
	localparam int FW = bbcm_pkg::FLAG_W;

	logic [15:0]   tag_dev_q [BUFFER_COUNT];
	logic [23:0]   tag_blk_q [BUFFER_COUNT];
	logic [FW-1:0] flags_q   [BUFFER_COUNT];
	logic [PW-1:0] next_q    [BUFFER_COUNT+1];
	logic [PW-1:0] prev_q    [BUFFER_COUNT+1];

	logic [2:0]  cmd_q;
	logic [15:0] dev_q;
	logic [23:0] blk_q;
	logic [3:0]  bidx_q;
	logic [PW-1:0] cur_q;
	logic [IW-1:0] scan_q;
	logic [bbcm_pkg::CNT_W-1:0] cnt_q;

	logic        pend_v_q;
	logic [2:0]  pend_kind_q;
	logic [3:0]  pend_buf_q;
	logic [15:0] pend_dev_q;
	logic [23:0] pend_blk_q;
	logic        pend_hit_q;

	logic [IW-1:0] cur_i;
	logic [PW-1:0] n_cur, p_cur, tail;
	logic [FW-1:0] cur_flags;
	logic          cur_end;
	logic [2:0]    e_kind;
	logic [3:0]    e_buf;
	logic [15:0]   e_dev;
	logic [23:0]   e_blk;
	logic          out_free;

	assign cur_i     = IW'(cur_q);
	assign cur_end   = (cur_q >= SENT);
	assign cur_flags = cur_end ? '0 : flags_q[cur_i];
	assign n_cur     = next_q[cur_q];
	assign p_cur     = prev_q[cur_q];
	assign tail      = prev_q[BUFFER_COUNT];
	assign out_free  = !out_valid || out_ready;

	assign e_kind = dcmd.kind;
	assign e_buf  = dcmd.emit_buf ? 4'(cur_q) : 4'd0;
	assign e_dev  = dcmd.emit_tags ? tag_dev_q[cur_i] : 16'd0;
	assign e_blk  = dcmd.emit_tags ? tag_blk_q[cur_i] : 24'd0;

	always_comb begin
		sts.cmd         = bbcm_pkg::cmd_code_t'(cmd_q);
		sts.dev_neg     = dev_q[15];
		sts.nodev       = !dev_q[15] && (dev_q[15:8] >= dev_count);
		sts.valid_b     = (32'(bidx_q) < 32'(BUFFER_COUNT));
		sts.scan_match  = (tag_dev_q[scan_q] == dev_q) && (tag_blk_q[scan_q] == blk_q);
		sts.scan_last   = (32'(scan_q) == 32'(BUFFER_COUNT - 1));
		sts.cur_flags   = cur_flags;
		sts.cur_end     = cur_end;
		sts.max_victims = (cnt_q >= bbcm_pkg::MAX_VICTIMS);
		sts.max_flush   = (cnt_q >= bbcm_pkg::MAX_FLUSH);
		sts.flush_match = !cur_end && ((cur_flags & bbcm_pkg::F_DELWRI) != '0) &&
			((dev_q == 16'hFFFF) || (dev_q == tag_dev_q[cur_i]));
		sts.emit_ok     = !pend_v_q || out_free;
		sts.out_free    = out_free;
	end

	// command registers and walk pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			scan_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (dcmd.load) begin
				cmd_q  <= in_cmd;
				dev_q  <= in_device;
				blk_q  <= in_block;
				bidx_q <= in_buffer;
				cnt_q  <= '0;
			end else if (dcmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (dcmd.cur_sel)
				bbcm_pkg::CUR_B:    cur_q <= PW'(in_buffer);
				bbcm_pkg::CUR_SCAN: cur_q <= PW'(scan_q);
				bbcm_pkg::CUR_HEAD: cur_q <= next_q[BUFFER_COUNT];
				bbcm_pkg::CUR_NEXT: cur_q <= n_cur;
				default: ;
			endcase
			if (dcmd.scan_clr)
				scan_q <= '0;
			else if (dcmd.scan_inc)
				scan_q <= scan_q + 1'b1;
		end
	end

	// tags, flags, free list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUFFER_COUNT; i++) begin
				tag_dev_q[i] <= 16'hFFFF;
				tag_blk_q[i] <= '0;
				flags_q[i]   <= '0;
				next_q[i]    <= PW'(i + 1);
				prev_q[i]    <= (i == 0) ? SENT : PW'(i - 1);
			end
			next_q[BUFFER_COUNT] <= '0;
			prev_q[BUFFER_COUNT] <= PW'(BUFFER_COUNT - 1);
		end else begin
			if (!cur_end && ((dcmd.fset | dcmd.fclr) != '0))
				flags_q[cur_i] <= (cur_flags & ~dcmd.fclr) | dcmd.fset;
			if (dcmd.tag_wr && !cur_end) begin
				tag_dev_q[cur_i] <= dev_q;
				tag_blk_q[cur_i] <= blk_q;
			end
			if (dcmd.unlink) begin
				next_q[p_cur] <= n_cur;
				prev_q[n_cur] <= p_cur;
			end
			if (dcmd.append) begin
				next_q[tail]         <= cur_q;
				prev_q[cur_q]        <= tail;
				next_q[cur_q]        <= SENT;
				prev_q[BUFFER_COUNT] <= cur_q;
			end
		end
	end

	// one result held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (dcmd.finish) begin
				out_valid  <= 1'b1;
				out_last   <= 1'b1;
				out_kind   <= pend_v_q ? pend_kind_q : 3'(bbcm_pkg::K_ACK);
				out_buffer <= pend_v_q ? pend_buf_q : 4'd0;
				out_device <= pend_v_q ? pend_dev_q : 16'd0;
				out_block  <= pend_v_q ? pend_blk_q : 24'd0;
				out_hit    <= pend_v_q && pend_hit_q;
				pend_v_q   <= 1'b0;
			end else if (dcmd.emit) begin
				if (pend_v_q) begin
					out_valid  <= 1'b1;
					out_last   <= 1'b0;
					out_kind   <= pend_kind_q;
					out_buffer <= pend_buf_q;
					out_device <= pend_dev_q;
					out_block  <= pend_blk_q;
					out_hit    <= pend_hit_q;
				end else if (out_ready) begin
					out_valid <= 1'b0;
				end
				pend_v_q    <= 1'b1;
				pend_kind_q <= e_kind;
				pend_buf_q  <= e_buf;
				pend_dev_q  <= e_dev;
				pend_blk_q  <= e_blk;
				pend_hit_q  <= dcmd.emit_hit;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule

>>> rtl/bbcm_ctrl.sv
// Controller FSM: sequences search, allocation, write-back, release and flush.
// Depends on bbcm_pkg; drives bbcm_dp.
module bbcm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bbcm_pkg::dp_sts_t  sts,
	output bbcm_pkg::dp_cmd_t  dcmd
);
	bbcm_pkg::state_t state_q, state_d, ret_q, ret_d;

	assign in_ready = (state_q == bbcm_pkg::S_IDLE);

	always_comb begin
		dcmd    = '0;
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			bbcm_pkg::S_IDLE: begin
				if (in_valid) begin
					dcmd.load    = 1'b1;
					dcmd.cur_sel = bbcm_pkg::CUR_B;
					state_d      = bbcm_pkg::S_DISP;
				end
			end
			bbcm_pkg::S_DISP: begin
				ret_d   = bbcm_pkg::S_FIN;
				state_d = bbcm_pkg::S_FIN;
				case (sts.cmd)
					bbcm_pkg::C_GET, bbcm_pkg::C_READ: begin
						if (sts.nodev) begin
							dcmd.emit = 1'b1;
							dcmd.kind = bbcm_pkg::K_NODEV;
						end else begin
							state_d = bbcm_pkg::S_SRCH0;
						end
					end
					bbcm_pkg::C_RELEASE: if (sts.valid_b) state_d = bbcm_pkg::S_REL1;
					bbcm_pkg::C_IODONE: begin
						if (sts.valid_b) begin
							dcmd.fset = bbcm_pkg::F_DONE;
							if ((sts.cur_flags & bbcm_pkg::F_ASYNC) != '0)
								state_d = bbcm_pkg::S_REL1;
							else
								dcmd.fclr = bbcm_pkg::F_WANTED;
						end
					end
					bbcm_pkg::C_WRITE: if (sts.valid_b) state_d = bbcm_pkg::S_WB;
					bbcm_pkg::C_DELWRI: begin
						if (sts.valid_b) begin
							dcmd.fset = bbcm_pkg::F_DELWRI | bbcm_pkg::F_DONE;
							state_d   = bbcm_pkg::S_REL1;
						end
					end
					bbcm_pkg::C_FLUSH: state_d = bbcm_pkg::S_FL0;
					default: ;
				endcase
			end
			bbcm_pkg::S_SRCH0: begin
				if (sts.dev_neg) begin
					state_d = bbcm_pkg::S_ALLOC;
				end else begin
					dcmd.scan_clr = 1'b1;
					state_d       = bbcm_pkg::S_SEARCH;
				end
			end
			bbcm_pkg::S_SEARCH: begin
				if (sts.scan_match) begin
					dcmd.cur_sel = bbcm_pkg::CUR_SCAN;
					state_d      = bbcm_pkg::S_MATCH;
				end else if (sts.scan_last) begin
					state_d = bbcm_pkg::S_ALLOC;
				end else begin
					dcmd.scan_inc = 1'b1;
				end
			end
			bbcm_pkg::S_MATCH: begin
				if ((sts.cur_flags & bbcm_pkg::F_BUSY) != '0) begin
					if (sts.emit_ok) begin
						dcmd.fset     = bbcm_pkg::F_WANTED;
						dcmd.emit     = 1'b1;
						dcmd.kind     = bbcm_pkg::K_BUSY;
						dcmd.emit_buf = 1'b1;
						state_d       = bbcm_pkg::S_FIN;
					end
				end else begin
					dcmd.unlink = 1'b1;
					dcmd.fset   = bbcm_pkg::F_BUSY;
					state_d     = bbcm_pkg::S_GRANT;
				end
			end
			bbcm_pkg::S_ALLOC: begin
				dcmd.cur_sel = bbcm_pkg::CUR_HEAD;
				state_d      = bbcm_pkg::S_ALLOC2;
			end
			bbcm_pkg::S_ALLOC2: begin
				if (sts.cur_end) begin
					if (sts.emit_ok) begin
						dcmd.emit   = 1'b1;
						dcmd.kind   = bbcm_pkg::K_NOFREE;
						state_d     = bbcm_pkg::S_FIN;
					end
				end else if ((sts.cur_flags & bbcm_pkg::F_DELWRI) != '0) begin
					if (sts.max_victims) begin
						if (sts.emit_ok) begin
							dcmd.emit = 1'b1;
							dcmd.kind = bbcm_pkg::K_BUSY;
							state_d   = bbcm_pkg::S_FIN;
						end
					end else begin
						dcmd.unlink = 1'b1;
						dcmd.fset   = bbcm_pkg::F_BUSY | bbcm_pkg::F_ASYNC;
						ret_d       = bbcm_pkg::S_SRCH0;
						state_d     = bbcm_pkg::S_WB;
					end
				end else begin
					dcmd.unlink = 1'b1;
					dcmd.fset   = bbcm_pkg::F_BUSY;
					state_d     = bbcm_pkg::S_CLAIM;
				end
			end
			bbcm_pkg::S_CLAIM: begin
				dcmd.fclr   = '1;
				dcmd.fset   = bbcm_pkg::F_BUSY;
				dcmd.tag_wr = 1'b1;
				state_d     = bbcm_pkg::S_GRANT;
			end
			bbcm_pkg::S_GRANT: begin
				if (sts.emit_ok) begin
					dcmd.emit      = 1'b1;
					dcmd.emit_tags = 1'b1;
					dcmd.emit_buf  = 1'b1;
					if (sts.cmd == bbcm_pkg::C_READ &&
						(sts.cur_flags & bbcm_pkg::F_DONE) == '0) begin
						dcmd.fset = bbcm_pkg::F_READ;
						dcmd.kind = bbcm_pkg::K_READ;
						state_d   = bbcm_pkg::S_GRANT2;
					end else begin
						dcmd.kind     = bbcm_pkg::K_GRANT;
						dcmd.emit_hit = (sts.cur_flags & bbcm_pkg::F_DONE) != '0;
						state_d       = bbcm_pkg::S_FIN;
					end
				end
			end
			bbcm_pkg::S_GRANT2: begin
				if (sts.emit_ok) begin
					dcmd.emit      = 1'b1;
					dcmd.emit_tags = 1'b1;
					dcmd.emit_buf  = 1'b1;
					dcmd.kind      = bbcm_pkg::K_GRANT;
					state_d        = bbcm_pkg::S_FIN;
				end
			end
			bbcm_pkg::S_WB: begin
				if (sts.emit_ok) begin
					dcmd.fclr      = bbcm_pkg::F_READ | bbcm_pkg::F_DONE |
						bbcm_pkg::F_ERROR | bbcm_pkg::F_DELWRI;
					dcmd.emit      = 1'b1;
					dcmd.kind      = bbcm_pkg::K_WRITE;
					dcmd.emit_tags = 1'b1;
					dcmd.emit_buf  = 1'b1;
					dcmd.cnt_inc   = 1'b1;
					if ((sts.cur_flags & bbcm_pkg::F_ASYNC) == '0)
						state_d = bbcm_pkg::S_REL1;
					else
						state_d = ret_q;
				end
			end
			bbcm_pkg::S_REL1: begin
				dcmd.unlink = (sts.cur_flags & bbcm_pkg::F_BUSY) == '0;
				state_d     = bbcm_pkg::S_REL2;
			end
			bbcm_pkg::S_REL2: begin
				dcmd.fclr   = bbcm_pkg::F_WANTED | bbcm_pkg::F_BUSY | bbcm_pkg::F_ASYNC;
				dcmd.append = 1'b1;
				state_d     = ret_q;
			end
			bbcm_pkg::S_FL0: begin
				if (sts.max_flush) begin
					state_d = bbcm_pkg::S_FIN;
				end else begin
					dcmd.cur_sel = bbcm_pkg::CUR_HEAD;
					state_d      = bbcm_pkg::S_FL1;
				end
			end
			bbcm_pkg::S_FL1: begin
				if (sts.cur_end) begin
					state_d = bbcm_pkg::S_FIN;
				end else if (sts.flush_match) begin
					dcmd.unlink = 1'b1;
					dcmd.fset   = bbcm_pkg::F_BUSY | bbcm_pkg::F_ASYNC;
					ret_d       = bbcm_pkg::S_FL0;
					state_d     = bbcm_pkg::S_WB;
				end else begin
					dcmd.cur_sel = bbcm_pkg::CUR_NEXT;
				end
			end
			bbcm_pkg::S_FIN: begin
				if (sts.out_free) begin
					dcmd.finish = 1'b1;
					state_d     = bbcm_pkg::S_IDLE;
				end
			end
			default: state_d = bbcm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbcm_pkg::S_IDLE;
			ret_q   <= bbcm_pkg::S_FIN;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end
endmodule

>>> rtl/block_buffer_cache_manager_unit.sv
// Top level of the block buffer cache manager: stream ports, APB register, controller
// and datapath. Depends on bbcm_pkg, bbcm_ctrl and bbcm_dp.
//
// Use: each input beat is one command (get, read, release, io done, write, delayed
// write, flush). The block answers with one or more result beats; the final beat of a
// command carries tlast, tuser carries the result kind.
// Sequencing: a command is taken only when the block is idle. A get walks the tag
// array one buffer per cycle and repeats the search after each delayed-write victim;
// a get or read for a device that does not exist answers without a search. A flush walks
// the free list one entry per cycle and restarts from the head after each write-back.
// Throughput: one command at a time; the sequencer and the single list/tag port set it.
// Results: one result is held back in a staging register so the final one can be
// marked; a stalled receiver (m_axis_tready low) simply holds the sequencer.
// Reset: arst_n clears all tags to no device, all flags, puts every buffer on the free
// list in index order and sets block_device_count to 1. No clearing pass.
// Config: block_device_count at byte address 0; the user writes it only while idle, the block does not enforce this.
module block_buffer_cache_manager_unit #(
	parameter int BUFFER_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // cmd[2:0], device[18:3], block_number[42:19], buffer_index[46:43]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // result_buffer[3:0], request_device[19:4], request_block[43:20], hit[44]
	output logic [2:0]  m_axis_tuser,  // kind[2:0]
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	bbcm_pkg::dp_cmd_t dcmd;
	bbcm_pkg::dp_sts_t sts;

	logic [7:0]  dev_count_q;
	logic [3:0]  r_buf;
	logic [15:0] r_dev;
	logic [23:0] r_blk;
	logic        r_hit;

	// register 0 sits at byte address 0; other addresses read zero and ignore writes
	assign pready = 1'b1;
	assign prdata = (paddr == bbcm_pkg::REG_DEV_COUNT) ? {24'd0, dev_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dev_count_q <= 8'd1;
		else if (psel && penable && pwrite && pready && paddr == bbcm_pkg::REG_DEV_COUNT)
			dev_count_q <= pwdata[7:0];
	end

	bbcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.dcmd     (dcmd)
	);

	bbcm_dp #(.BUFFER_COUNT(BUFFER_COUNT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dcmd       (dcmd),
		.sts        (sts),
		.dev_count  (dev_count_q),
		.in_cmd     (s_axis_tdata[2:0]),
		.in_device  (s_axis_tdata[18:3]),
		.in_block   (s_axis_tdata[42:19]),
		.in_buffer  (s_axis_tdata[46:43]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (m_axis_tuser),
		.out_buffer (r_buf),
		.out_device (r_dev),
		.out_block  (r_blk),
		.out_hit    (r_hit),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, r_hit, r_blk, r_dev, r_buf};
endmodule

>>> rtl/bbcm_chk.sv
// Port-level checker for the block buffer cache manager, bound to the top level.
// Depends on block_buffer_cache_manager_unit_defines.svh.
`include "block_buffer_cache_manager_unit_defines.svh"
module bbcm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	`BBCM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
	`BBCM_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
	`BBCM_ASSERT_NEXT(a_one_cmd, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second command taken while busy")
	`BBCM_ASSERT(a_idle_last, s_axis_tready && m_axis_tvalid, m_axis_tlast, "idle with a non-final result pending")
	`BBCM_ASSERT(a_kind_range, m_axis_tvalid, m_axis_tuser != 3'd7, "undefined result kind")
endmodule

bind block_buffer_cache_manager_unit bbcm_chk u_bbcm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
